// File: hdl/iac_pkg.sv
package iac_pkg;

   localparam int WORD_W   = 32;
   localparam int OPCODE_W = 2;
   localparam int POS_W    = 11;
   localparam int STATUS_W = 2;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_GET    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic do_insert;
      logic do_delete;
      logic do_load;
      logic do_shift;
   } cell_ctrl_type;

endpackage

// File: hdl/iac_if.sv
interface iac_req_if import iac_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   word_type            value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface iac_rsp_if import iac_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   word_type            read_value;
   logic [POS_W-1:0]    count;

   modport source (output valid, output status, output read_value, output count, input ready);
   modport sink (input valid, input status, input read_value, input count, output ready);
endinterface

// File: hdl/indexed_array_list.sv
// Ordered list of signed 32-bit words with one-based positions, held in a row of
// DEPTH cells that shift together. Insert, delete, an unused opcode and any
// rejected operation finish in the cycle of their transfer, so such items can
// follow one another every cycle and each result appears in the next cycle. A
// successful get at position p copies the row into a read tap chain and shifts it
// toward the first cell one step per cycle until word p reaches the first tap,
// then offers its result; no new item is taken meanwhile. A result waiting in the
// output register blocks a new transfer only if it is not taken in that cycle.
module indexed_array_list import iac_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input logic        clock,
   input logic        reset,
   iac_req_if.sink    req_bus,
   iac_rsp_if.source  rsp_bus
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]   rsp_rdval_ff, rsp_rdval_in;
   logic [POS_W-1:0]    rsp_count_ff, rsp_count_in;

   cell_ctrl_type       ctrl;
   logic                accept;
   logic                rsp_free;
   logic [CMP_W-1:0]    pos_ext, len_ext, pos_m1, len_in_ext;
   logic [IDX_W-1:0]    idx;
   logic                ins_range, acc_range, full;

   logic [WORD_W-1:0]   entry [DEPTH];
   logic [WORD_W-1:0]   tap [DEPTH];

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign pos_ext    = CMP_W'(req_bus.position);
   assign len_ext    = CMP_W'(len_ff);
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign idx        = pos_m1[IDX_W-1:0];
   assign ins_range  = (pos_ext == '0) || (pos_ext > len_ext + CMP_W'(1));
   assign acc_range  = (pos_ext == '0) || (pos_ext > len_ext);
   assign full       = (len_ext == CMP_W'(DEPTH));
   assign len_in_ext = CMP_W'(len_in);

   always_comb begin
      ctrl          = '0;
      state_in      = state_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rdval_in  = rsp_rdval_ff;
      rsp_count_in  = rsp_count_ff;
      if (state_ff == ST_IDLE) begin
         if (accept) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_rdval_in  = '0;
            case (req_bus.opcode)
               OP_INSERT: begin
                  if (ins_range) begin
                     rsp_status_in = STATUS_RANGE;
                  end else if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     ctrl.do_insert = 1'b1;
                     len_in         = len_ff + LEN_W'(1);
                  end
               end
               OP_DELETE: begin
                  if (acc_range) begin
                     rsp_status_in = STATUS_RANGE;
                  end else begin
                     ctrl.do_delete = 1'b1;
                     len_in         = len_ff - LEN_W'(1);
                  end
               end
               OP_GET: begin
                  if (acc_range) begin
                     rsp_status_in = STATUS_RANGE;
                  end else begin
                     ctrl.do_load = 1'b1;
                     cnt_in       = idx;
                     state_in     = ST_SCAN;
                     rsp_valid_in = 1'b0;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_OK;
               end
            endcase
            rsp_count_in = len_in_ext[POS_W-1:0];
         end
      end else begin
         if (cnt_ff != '0) begin
            ctrl.do_shift = 1'b1;
            cnt_in        = cnt_ff - IDX_W'(1);
         end else if (rsp_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_rdval_in  = tap[0];
            rsp_count_in  = len_in_ext[POS_W-1:0];
            state_in      = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_rdval_ff  <= rsp_rdval_in;
      rsp_count_ff  <= rsp_count_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_entry;
      logic [WORD_W-1:0] right_entry;
      logic [WORD_W-1:0] right_tap;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_mid_l
         assign left_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
         assign right_tap   = '0;
      end else begin : g_mid_r
         assign right_entry = entry[i+1];
         assign right_tap   = tap[i+1];
      end

      iac_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .idx         (idx),
         .value       (req_bus.value),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .right_tap   (right_tap),
         .entry       (entry[i]),
         .tap         (tap[i])
      );
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_rdval_ff;
   assign rsp_bus.count      = rsp_count_ff;

endmodule

// File: hdl/iac_cell.sv
module iac_cell import iac_pkg::*; #(
   parameter int IDX_W = 10,
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [IDX_W-1:0]   idx,
   input  logic [WORD_W-1:0]  value,
   input  logic [WORD_W-1:0]  left_entry,
   input  logic [WORD_W-1:0]  right_entry,
   input  logic [WORD_W-1:0]  right_tap,
   output logic [WORD_W-1:0]  entry,
   output logic [WORD_W-1:0]  tap
);

   localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

   logic [WORD_W-1:0] entry_ff, entry_in;
   logic [WORD_W-1:0] tap_ff, tap_in;

   always_comb begin
      entry_in = entry_ff;
      tap_in   = tap_ff;
      if (ctrl.do_insert) begin
         if (ME == idx) begin
            entry_in = value;
         end else if (ME > idx) begin
            entry_in = left_entry;
         end
      end
      if (ctrl.do_delete && (ME >= idx)) begin
         entry_in = right_entry;
      end
      if (ctrl.do_load) begin
         tap_in = entry_ff;
      end else if (ctrl.do_shift) begin
         tap_in = right_tap;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule
